/* src/ws2812_pkg.sv */
// Shared types and constants for the WS2812 bit waveform encoder.
package ws2812_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_PERIOD_TOP     = 2'd0;
    localparam logic [1:0] REG_HIGH_TIME_ONE  = 2'd1;
    localparam logic [1:0] REG_HIGH_TIME_ZERO = 2'd2;
    localparam logic [1:0] REG_LATCH_PERIODS  = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Reset values of the configuration registers.
    localparam logic [7:0] RESET_PERIOD_TOP     = 8'd20;
    localparam logic [7:0] RESET_HIGH_TIME_ONE  = 8'd14;
    localparam logic [7:0] RESET_HIGH_TIME_ZERO = 8'd7;
    localparam logic [5:0] RESET_LATCH_PERIODS  = 6'd20;

    // Item function codes.
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // Width of the slot counter and of the padded color word used for alignment.
    localparam int SLOT_W       = 7;
    localparam int GRB_W        = 24;
    localparam int COLOR_WIDE_W = 56;

    typedef struct packed {
        logic [7:0] period_top;
        logic [7:0] high_time_one;
        logic [7:0] high_time_zero;
        logic [5:0] latch_periods;
    } cfg_t;

    typedef struct packed {
        logic       func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } item_t;

    typedef struct packed {
        logic data_line;
        logic busy_res;
        logic frame_done;
    } result_t;

endpackage

/* src/ws2812_cfg_regs.sv */
// Configuration register bank of the WS2812 encoder.
module ws2812_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ws2812_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ws2812_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output ws2812_pkg::cfg_t                    cfg
);

    ws2812_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_top     <= ws2812_pkg::RESET_PERIOD_TOP;
            cfg_reg.high_time_one  <= ws2812_pkg::RESET_HIGH_TIME_ONE;
            cfg_reg.high_time_zero <= ws2812_pkg::RESET_HIGH_TIME_ZERO;
            cfg_reg.latch_periods  <= ws2812_pkg::RESET_LATCH_PERIODS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ws2812_pkg::REG_PERIOD_TOP:     cfg_reg.period_top     <= cfg_wdata;
                ws2812_pkg::REG_HIGH_TIME_ONE:  cfg_reg.high_time_one  <= cfg_wdata;
                ws2812_pkg::REG_HIGH_TIME_ZERO: cfg_reg.high_time_zero <= cfg_wdata;
                ws2812_pkg::REG_LATCH_PERIODS:  cfg_reg.latch_periods  <= cfg_wdata[5:0];
                default:                        cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/ws2812_encoder.sv */
// Frame state and single-pass step logic of the WS2812 encoder.
module ws2812_encoder
#(
    parameter int COLOR_BITS  = 24,
    parameter int TIMER_WIDTH = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  ws2812_pkg::item_t    item,
    input  ws2812_pkg::cfg_t     cfg,
    output ws2812_pkg::result_t  result,
    output logic                 active
);

    localparam int CMP_W = (TIMER_WIDTH > 8) ? TIMER_WIDTH : 8;
    localparam logic [CMP_W-1:0] TIMER_MAX = CMP_W'((1 << TIMER_WIDTH) - 1);
    localparam logic [ws2812_pkg::SLOT_W-1:0] BIT_SLOTS = ws2812_pkg::SLOT_W'(COLOR_BITS);

    logic [COLOR_BITS-1:0]          color_shift_reg, color_shift_next;
    logic [TIMER_WIDTH-1:0]         count_reg, count_next;
    logic [ws2812_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic                           active_reg, active_next;

    logic [ws2812_pkg::COLOR_WIDE_W-1:0] grb_wide;
    logic [CMP_W-1:0]                    period_ext;
    logic [CMP_W-1:0]                    top;
    logic [CMP_W-1:0]                    count_ext;
    logic [CMP_W-1:0]                    high_time;
    logic [ws2812_pkg::SLOT_W-1:0]       slot_inc;
    logic [ws2812_pkg::SLOT_W-1:0]       frame_end;
    logic                                in_bits;
    logic                                period_end;

    // The color word is left aligned so the frame keeps its most significant bits.
    assign grb_wide = {item.green, item.red, item.blue,
                       (ws2812_pkg::COLOR_WIDE_W - ws2812_pkg::GRB_W)'(0)};

    assign period_ext = CMP_W'(cfg.period_top);
    assign top        = (period_ext > TIMER_MAX) ? TIMER_MAX : period_ext;
    assign count_ext  = CMP_W'(count_reg);
    assign high_time  = color_shift_reg[COLOR_BITS-1] ? CMP_W'(cfg.high_time_one)
                                                      : CMP_W'(cfg.high_time_zero);
    assign in_bits    = slot_reg < BIT_SLOTS;
    assign period_end = count_ext >= top;
    assign slot_inc   = slot_reg + ws2812_pkg::SLOT_W'(1);
    assign frame_end  = BIT_SLOTS + ws2812_pkg::SLOT_W'(cfg.latch_periods);

    always_comb
    begin
        color_shift_next  = color_shift_reg;
        count_next        = count_reg;
        slot_next         = slot_reg;
        active_next       = active_reg;
        result.data_line  = 1'b0;
        result.busy_res   = 1'b0;
        result.frame_done = 1'b0;
        if (item.func == ws2812_pkg::FUNC_LOAD)
        begin
            color_shift_next = grb_wide[ws2812_pkg::COLOR_WIDE_W-1 -: COLOR_BITS];
            count_next       = '0;
            slot_next        = '0;
            active_next      = 1'b1;
            result.busy_res  = 1'b1;
        end
        else if (active_reg)
        begin
            result.busy_res  = 1'b1;
            result.data_line = in_bits && (count_ext < high_time);
            if (period_end)
            begin
                count_next = '0;
                slot_next  = slot_inc;
                if (in_bits)
                begin
                    color_shift_next = {color_shift_reg[COLOR_BITS-2:0], 1'b0};
                end
                if (slot_inc >= frame_end)
                begin
                    result.frame_done = 1'b1;
                    active_next       = 1'b0;
                    slot_next         = '0;
                end
            end
            else
            begin
                count_next = count_reg + TIMER_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_shift_reg <= '0;
            count_reg       <= '0;
            slot_reg        <= '0;
            active_reg      <= 1'b0;
        end
        else if (advance)
        begin
            color_shift_reg <= color_shift_next;
            count_reg       <= count_next;
            slot_reg        <= slot_next;
            active_reg      <= active_next;
        end
    end

    assign active = active_reg;

endmodule

/* src/ws2812_pwm_bit_waveform_top.sv */
// Top level of the WS2812 PWM bit waveform encoder with stream ports.
//
// This block turns a stream of timer ticks into the single-wire WS2812 LED data
// waveform. A transaction with tuser set loads the red, green and blue bytes and
// starts (or restarts) a frame; a transaction with tuser clear is one timer count.
// Every input transaction yields exactly one output transaction carrying the line
// level for that count, a busy flag, and tlast on the count that ends the latch
// phase. A frame is COLOR_BITS bit periods sent most significant bit first in
// green, red, blue order, followed by latch_periods low periods. The block takes
// one transaction per clock cycle, sustained while m_tready is held high. An
// accepted transaction is held in the input register and passes through the step
// logic into the result register, from which its result is presented. The frame
// counters take a single step per transaction. The block holds at most two
// transactions, one in each register; the input side accepts whenever the input
// register is empty or its transaction moves into the result register in the
// same cycle, which happens when the result register is empty or is being read.
// While a result waits with tready low and the input register is full, s_tready
// stays low.
// Configuration writes are meant to be issued while no transaction is in flight.
module ws2812_pwm_bit_waveform_top
#(
    parameter int COLOR_BITS  = 24,
    parameter int TIMER_WIDTH = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // red, green, blue
    input  logic                                s_tuser,   // func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // data_line, busy_res, zero pad
    output logic                                m_tlast,   // frame_done
    input  logic                                cfg_we,
    input  logic [ws2812_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ws2812_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    ws2812_pkg::cfg_t     cfg;
    ws2812_pkg::item_t    in_item_reg;
    ws2812_pkg::result_t  step_result;
    ws2812_pkg::result_t  out_result_reg;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 enc_active;

    ws2812_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held transaction moves on when the result register is empty or is
    // being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.func  <= s_tuser;
            in_item_reg.red   <= s_tdata[7:0];
            in_item_reg.green <= s_tdata[15:8];
            in_item_reg.blue  <= s_tdata[23:16];
        end
    end

    ws2812_encoder
    #(
        .COLOR_BITS  (COLOR_BITS),
        .TIMER_WIDTH (TIMER_WIDTH)
    )
    u_encoder
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result),
        .active  (enc_active)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_result_reg.busy_res, out_result_reg.data_line};
    assign m_tlast  = out_result_reg.frame_done;

    // The end of a frame is only ever reported while the frame is still busy.
    a_done_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.frame_done |-> out_result_reg.busy_res)
        else $error("frame_done raised without busy_res");

    // The line is never driven high outside a frame.
    a_line_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.data_line |-> out_result_reg.busy_res)
        else $error("data_line high while idle");

    // A load that is processed always leaves the encoder sending a frame.
    a_load_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.func == ws2812_pkg::FUNC_LOAD) |=> enc_active)
        else $error("load did not start a frame");

    // An empty input register can always take a new transaction.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while its register is empty");

endmodule
